// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the extremum interval detector.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge while out of reset
`define LEID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset cycles included
`define LEID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LEID_ASSERT(lbl, prop, msg)
`define LEID_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/core/leid_pkg.sv -----
// Shared types and constants of the extremum interval detector.
// No dependencies; used by the queue, the back part and the top level.
`timescale 1ns / 1ps
package leid_pkg;

  // Result queue depth (power of two, pointers wrap on their own)
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Queue status seen by the back part and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/leid_front.sv -----
// Front part: accepts samples, tracks trend and open intervals, builds queue entries.
// Depends on nothing but its parameters; entry layout is shared with leid_back.
`timescale 1ns / 1ps
module leid_front #(
  parameter int INDEX_BITS  = 16,
  parameter int SAMPLE_BITS = 32,
  localparam int RES_W      = 2 * INDEX_BITS + 1,
  localparam int ENTRY_W    = 2 * RES_W + 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          series_end,
  output logic                          push,
  output logic [ENTRY_W-1:0]            push_data
);

  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic [INDEX_BITS-1:0]         count_r, count_nxt;
  logic                          top_used_r, top_used_nxt;
  logic                          rise_v_r, rise_v_nxt;
  logic [INDEX_BITS-1:0]         rise_i_r, rise_i_nxt;
  logic                          fall_v_r, fall_v_nxt;
  logic [INDEX_BITS-1:0]         fall_i_r, fall_i_nxt;

  logic [INDEX_BITS-1:0] idx, prev_idx;
  logic                  active, second, gt, lt;
  logic [4:0]            em_v;
  logic [RES_W-1:0]      em [5];
  logic [RES_W-1:0]      r0, r1;
  logic                  have0, have1;

  // Current and previous sample index, saturating at the top
  always_comb begin
    idx      = top_used_r ? {INDEX_BITS{1'b1}} : count_r;
    prev_idx = top_used_r ? {INDEX_BITS{1'b1}} : count_r - INDEX_BITS'(1);
    active   = top_used_r || (count_r != '0);
    second   = !top_used_r && (count_r == INDEX_BITS'(1));
    gt       = sample > prev_r;
    lt       = sample < prev_r;
  end

  // Classify the trend, update open intervals and collect the intervals closed here
  always_comb begin
    rise_v_nxt = rise_v_r;
    rise_i_nxt = rise_i_r;
    fall_v_nxt = fall_v_r;
    fall_i_nxt = fall_i_r;
    em_v       = '0;
    for (int k = 0; k < 5; k++) begin
      em[k] = '0;
    end
    if (active) begin
      // Second sample: first sample becomes an extremum, or a flat start opens both
      if (second) begin
        if (lt) begin
          em_v[0] = 1'b1;
          em[0]   = {1'b1, {INDEX_BITS{1'b0}}, {INDEX_BITS{1'b0}}};
        end else if (gt) begin
          em_v[0] = 1'b1;
          em[0]   = {1'b0, {INDEX_BITS{1'b0}}, {INDEX_BITS{1'b0}}};
        end else begin
          rise_v_nxt = 1'b1;
          rise_i_nxt = '0;
          fall_v_nxt = 1'b1;
          fall_i_nxt = '0;
        end
      end
      if (gt) begin
        rise_v_nxt = 1'b1;
        rise_i_nxt = idx;
      end
      if (lt) begin
        fall_v_nxt = 1'b1;
        fall_i_nxt = idx;
      end
      // Close a maximum on a fall
      if (lt && rise_v_nxt && !second) begin
        em_v[1]    = 1'b1;
        em[1]      = {1'b1, prev_idx, rise_i_nxt};
        rise_v_nxt = 1'b0;
      end
      // Close a minimum on a rise
      if (gt && fall_v_nxt && !second) begin
        em_v[2]    = 1'b1;
        em[2]      = {1'b0, prev_idx, fall_i_nxt};
        fall_v_nxt = 1'b0;
      end
      // Close what is still open at the last sample
      if (series_end) begin
        if (rise_v_nxt && !lt) begin
          em_v[3] = 1'b1;
          em[3]   = {1'b1, idx, rise_i_nxt};
        end
        if (fall_v_nxt && !gt) begin
          em_v[4] = 1'b1;
          em[4]   = {1'b0, idx, fall_i_nxt};
        end
      end
    end
  end

  // Pack the at most two intervals in order
  always_comb begin
    r0    = '0;
    r1    = '0;
    have0 = 1'b0;
    have1 = 1'b0;
    for (int k = 0; k < 5; k++) begin
      if (em_v[k]) begin
        if (!have0) begin
          r0    = em[k];
          have0 = 1'b1;
        end else if (!have1) begin
          r1    = em[k];
          have1 = 1'b1;
        end
      end
    end
  end

  assign push      = accept && have0;
  assign push_data = {top_used_r, have1, r1, r0};

  // Advance the index, saturating at the top
  always_comb begin
    count_nxt    = count_r;
    top_used_nxt = top_used_r;
    if (!top_used_r) begin
      if (count_r == {INDEX_BITS{1'b1}}) begin
        top_used_nxt = 1'b1;
      end else begin
        count_nxt = count_r + INDEX_BITS'(1);
      end
    end
  end

  // Hold series state; return to reset after the last sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      count_r    <= '0;
      top_used_r <= 1'b0;
      rise_v_r   <= 1'b0;
      rise_i_r   <= '0;
      fall_v_r   <= 1'b0;
      fall_i_r   <= '0;
    end else if (accept) begin
      if (series_end) begin
        prev_r     <= '0;
        count_r    <= '0;
        top_used_r <= 1'b0;
        rise_v_r   <= 1'b0;
        rise_i_r   <= '0;
        fall_v_r   <= 1'b0;
        fall_i_r   <= '0;
      end else begin
        prev_r     <= sample;
        count_r    <= count_nxt;
        top_used_r <= top_used_nxt;
        rise_v_r   <= rise_v_nxt;
        rise_i_r   <= rise_i_nxt;
        fall_v_r   <= fall_v_nxt;
        fall_i_r   <= fall_i_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/leid_queue.sv -----
// Short queue of result entries between the front and back parts.
// Depends on leid_pkg for depth and the status struct.
`timescale 1ns / 1ps
module leid_queue
  import leid_pkg::*;
#(
  parameter int W = 35
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output q_stat_t      stat
);

  logic [W-1:0]      mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W + 1)'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/leid_back.sv -----
// Back part: sends the one or two intervals of each queue entry on the result stream.
// Depends on leid_pkg for the queue status; entry layout follows leid_front.
`timescale 1ns / 1ps
module leid_back
  import leid_pkg::*;
#(
  parameter int INDEX_BITS  = 16,
  localparam int RES_W      = 2 * INDEX_BITS + 1,
  localparam int ENTRY_W    = 2 * RES_W + 2,
  localparam int OUT_DATA_W = ((2 * INDEX_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ENTRY_W-1:0]    head,
  input  q_stat_t               stat,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  logic             sel_r, sel_nxt;
  logic [RES_W-1:0] res;
  logic             two, ovf, take;

  assign two  = head[2 * RES_W];
  assign ovf  = head[2 * RES_W + 1];
  assign res  = sel_r ? head[2 * RES_W - 1:RES_W] : head[RES_W - 1:0];
  assign take = out_tvalid && out_tready;

  // Drive the result request
  assign out_tvalid = !stat.empty;
  assign out_tdata  = OUT_DATA_W'(res[2 * INDEX_BITS - 1:0]);
  assign out_tuser  = {ovf, res[2 * INDEX_BITS]};
  assign out_tlast  = !two || sel_r;
  assign pop        = take && out_tlast;

  // Step to the second interval, back to the first on pop
  always_comb begin
    sel_nxt = sel_r;
    if (take) begin
      sel_nxt = !out_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

// ----- rtl/core/local_extremum_interval_detector_unit.sv -----
// Top level of the local extremum interval detector.
// Depends on leid_pkg, leid_front, leid_queue, leid_back and assert_macros.svh.
//
// Usage:
//   Input stream: one signed sample per request in in_tdata, in_tlast on the
//   final sample of a series. Result stream: one extremum interval per
//   request, start and end index in out_tdata, kind and overflow in out_tuser,
//   out_tlast on the last interval caused by one sample.
//   A sample is taken in the cycle it is offered while the four-entry result
//   queue has room; a sample that closes intervals has its entry registered
//   in the queue before any result is offered. Sustained rate is one sample
//   per cycle while the queue has room, set by the trend compare and register
//   update in the front part; the output port sends one interval per cycle
//   while out_tready is high, so a sample that closes two intervals holds the
//   port for both and the queue absorbs it. Indices saturate at the top
//   value and raise the overflow flag until the series ends. After the final
//   sample the series state returns to reset. Reset (synchronous, active low)
//   empties the queue and clears all series state. When the receiver stalls,
//   results wait in the queue and in_tready drops once it is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module local_extremum_interval_detector_unit
  import leid_pkg::*;
#(
  parameter int INDEX_BITS  = 16,
  parameter int SAMPLE_BITS = 32,
  localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((2 * INDEX_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // bits from 0: sample
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bits from 0: start_index, end_index
  output logic [OUT_DATA_W-1:0] out_tdata,
  // bits from 0: is_maximum, index_overflow
  output logic [1:0]            out_tuser,
  output logic                  out_tlast
);

  localparam int RES_W   = 2 * INDEX_BITS + 1;
  localparam int ENTRY_W = 2 * RES_W + 2;

  logic               accept, push, pop;
  logic [ENTRY_W-1:0] push_data, head;
  q_stat_t            q_stat;

  // Take a sample while the queue has room
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  leid_front #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .series_end (in_tlast),
    .push       (push),
    .push_data  (push_data)
  );

  leid_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  leid_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .stat       (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Checks on the decoupling between front and back
  `LEID_ASSERT(a_no_push_full, push |-> !q_stat.full, "push into a full queue")
  `LEID_ASSERT(a_push_on_accept, push |-> accept, "queue push without an accepted sample")
  `LEID_ASSERT(a_pop_on_last, pop |-> (out_tvalid && out_tready && out_tlast), "pop without last result taken")
  `LEID_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule
